// ===== hdl/mark_sweep_slot_allocator_unit_assert.svh =====
// Assertion macros shared by the allocator RTL.
// Both macros sample on the rising edge of clk and are held off during reset.
`ifndef MARK_SWEEP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define MARK_SWEEP_SLOT_ALLOCATOR_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/msa_pkg.sv =====
// ----------------------------------------------------------------------------
// msa_pkg
// Types, sizes and codes shared by the mark-sweep slot allocator.
// ----------------------------------------------------------------------------
package msa_pkg;

  localparam int SLOTS_PER_CHUNK = 256;
  localparam int NUM_CHUNKS      = 16;
  localparam int TOTAL_SLOTS     = SLOTS_PER_CHUNK * NUM_CHUNKS;

  localparam int SLOT_W    = 12;
  localparam int CNT_W     = 13;
  localparam int THR_W     = 14;
  localparam int BASE_W    = 13;
  localparam int MAP_W     = 64;
  localparam int BIT_W     = $clog2(MAP_W);
  localparam int MAP_WORDS = TOTAL_SLOTS / MAP_W;
  localparam int WORD_W    = $clog2(MAP_WORDS);
  localparam int PUSH_W    = $clog2(SLOTS_PER_CHUNK);
  localparam int CHUNK_W   = $clog2(NUM_CHUNKS + 1);

  localparam logic [BASE_W-1:0] BASE_THR_RESET = BASE_W'(1024);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_MARK  = 2'd1,
    CMD_SWEEP = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_COLLECT = 2'd1,
    STAT_OOM     = 2'd2,
    STAT_BADSLOT = 2'd3
  } status_t;

  typedef enum logic {
    REG_COLLECT_ENABLE = 1'b0,
    REG_BASE_THRESHOLD = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        command;
    logic [SLOT_W-1:0] slot_number;
    logic              is_vector;
  } in_word_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] given_slot;
    logic              already_marked;
    logic [CNT_W-1:0]  freed_count;
    logic [CNT_W-1:0]  live_count;
  } out_word_t;

  // One bitmap word: live, mark and vector bits of 64 consecutive slots.
  typedef struct packed {
    logic [MAP_W-1:0] live;
    logic [MAP_W-1:0] mark;
    logic [MAP_W-1:0] vec;
  } map_word_t;

endpackage

// ===== hdl/mark_sweep_slot_allocator_unit.sv =====
// Allocate: an empty stack first gets a new chunk; pop a slot, then set its live bit.
// Mark: read the word, set its mark bit; refusals and command 3 skip to the result.
// Sweep: each active 64-slot word is read, written back, tested one bit per cycle.
// One item at a time; stack and bitmap memories have separate read and write ports.
// Reset (synchronous, rst_n low) empties the stack and marks all bitmap words unwritten.
// ----------------------------------------------------------------------------
// mark_sweep_slot_allocator_unit
// Slot allocator with live/mark/vector bitmaps, a free-slot LIFO and sweep.
// ----------------------------------------------------------------------------
`include "mark_sweep_slot_allocator_unit_assert.svh"

module mark_sweep_slot_allocator_unit import msa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_ACT     = 11'b00000000010,
    S_POP_RD  = 11'b00000000100,
    S_POP_MAP = 11'b00000001000,
    S_POP_WR  = 11'b00000010000,
    S_MARK_WR = 11'b00000100000,
    S_SW_RD   = 11'b00001000000,
    S_SW_DAT  = 11'b00010000000,
    S_SW_BIT  = 11'b00100000000,
    S_SW_END  = 11'b01000000000,
    S_FINISH  = 11'b10000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic                collect_enable_r;
  logic [BASE_W-1:0]   base_threshold_r;
  logic [CNT_W-1:0]    free_depth_r, free_depth_nxt;
  logic [CHUNK_W-1:0]  chunks_r, chunks_nxt;
  logic [CNT_W-1:0]    limit_r, limit_nxt;
  logic [CNT_W-1:0]    live_r, live_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic [PUSH_W-1:0]   push_cnt_r, push_cnt_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [BIT_W-1:0]    bit_r, bit_nxt;
  logic [MAP_W-1:0]    fmask_r, fmask_nxt;
  logic [CNT_W-1:0]    freed_r, freed_nxt;
  in_word_t            cmd_r, cmd_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  out_word_t           res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  logic [SLOT_W-1:0]   stack_mem [TOTAL_SLOTS];
  logic [SLOT_W-1:0]   stack_q_r;
  logic                st_wr_en, st_rd_en;
  logic [SLOT_W-1:0]   st_wr_addr, st_wr_data, st_rd_addr;

  logic                map_rd_en, map_wr_en;
  logic [WORD_W-1:0]   map_rd_addr, map_wr_addr;
  map_word_t           map_q, map_wr_data;

  logic                cfg_wr;
  logic [CNT_W-1:0]    sw_live;
  logic [THR_W-1:0]    sw_twice;
  logic [MAP_W-1:0]    sw_free;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collect_enable_r <= 1'b0;
      base_threshold_r <= BASE_THR_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_COLLECT_ENABLE: collect_enable_r <= pwdata[0];
        REG_BASE_THRESHOLD: base_threshold_r <= pwdata[BASE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx_t'(paddr[2]))
      REG_COLLECT_ENABLE: prdata = 32'(collect_enable_r);
      REG_BASE_THRESHOLD: prdata = 32'(base_threshold_r);
      default: ;
    endcase
  end

  // ---------------- memories ----------------
  always_ff @(posedge clk) begin
    if (st_wr_en) begin
      stack_mem[st_wr_addr] <= st_wr_data;
    end
    if (st_rd_en) begin
      stack_q_r <= stack_mem[st_rd_addr];
    end
  end

  msa_map_mem u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (map_rd_en),
    .rd_addr (map_rd_addr),
    .rd_data (map_q),
    .wr_en   (map_wr_en),
    .wr_addr (map_wr_addr),
    .wr_data (map_wr_data)
  );

  // Sweep arithmetic: new live count and the next threshold.
  assign sw_live  = (freed_r <= live_r) ? (live_r - freed_r) : '0;
  assign sw_twice = {sw_live, 1'b0};
  assign sw_free  = map_q.live & ~map_q.mark;

  assign in_stall = (state_r != S_IDLE);

  // ---------------- control ----------------
  always_comb begin
    state_nxt      = state_r;
    free_depth_nxt = free_depth_r;
    chunks_nxt     = chunks_r;
    limit_nxt      = limit_r;
    live_nxt       = live_r;
    thr_nxt        = thr_r;
    push_cnt_nxt   = push_cnt_r;
    word_nxt       = word_r;
    bit_nxt        = bit_r;
    fmask_nxt      = fmask_r;
    freed_nxt      = freed_r;
    cmd_nxt        = cmd_r;
    slot_nxt       = slot_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    st_wr_en       = 1'b0;
    st_wr_addr     = free_depth_r[SLOT_W-1:0];
    st_wr_data     = '0;
    st_rd_en       = 1'b0;
    st_rd_addr     = SLOT_W'(free_depth_r - 1'b1);
    map_rd_en      = 1'b0;
    map_rd_addr    = word_r;
    map_wr_en      = 1'b0;
    map_wr_addr    = word_r;
    map_wr_data    = map_q;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_data;
          res_nxt = '0;
          unique case (cmd_t'(in_data.command))
            CMD_ALLOC: begin
              if (collect_enable_r && ({1'b0, live_r} >= thr_r)) begin
                res_nxt.status = STAT_COLLECT;
                state_nxt      = S_FINISH;
              end else if (free_depth_r != '0) begin
                state_nxt = S_POP_RD;
              end else if (chunks_r < CHUNK_W'(NUM_CHUNKS)) begin
                push_cnt_nxt = '0;
                state_nxt    = S_ACT;
              end else begin
                res_nxt.status = STAT_OOM;
                state_nxt      = S_FINISH;
              end
            end
            CMD_MARK: begin
              if ({1'b0, in_data.slot_number} >= limit_r) begin
                res_nxt.status = STAT_BADSLOT;
                state_nxt      = S_FINISH;
              end else begin
                map_rd_en   = 1'b1;
                map_rd_addr = in_data.slot_number[SLOT_W-1:BIT_W];
                state_nxt   = S_MARK_WR;
              end
            end
            CMD_SWEEP: begin
              word_nxt  = '0;
              freed_nxt = '0;
              state_nxt = (limit_r == '0) ? S_SW_END : S_SW_RD;
            end
            default: state_nxt = S_FINISH;
          endcase
        end
      end

      // Push the new chunk's slots in ascending order, one per cycle.
      S_ACT: begin
        st_wr_en       = 1'b1;
        st_wr_data     = SLOT_W'(limit_r) + SLOT_W'(push_cnt_r);
        free_depth_nxt = free_depth_r + 1'b1;
        push_cnt_nxt   = push_cnt_r + 1'b1;
        if (push_cnt_r == PUSH_W'(SLOTS_PER_CHUNK - 1)) begin
          limit_nxt  = limit_r + CNT_W'(SLOTS_PER_CHUNK);
          chunks_nxt = chunks_r + 1'b1;
          state_nxt  = S_POP_RD;
        end
      end

      S_POP_RD: begin
        st_rd_en       = 1'b1;
        free_depth_nxt = free_depth_r - 1'b1;
        state_nxt      = S_POP_MAP;
      end

      S_POP_MAP: begin
        slot_nxt    = stack_q_r;
        map_rd_en   = 1'b1;
        map_rd_addr = stack_q_r[SLOT_W-1:BIT_W];
        state_nxt   = S_POP_WR;
      end

      S_POP_WR: begin
        map_wr_en                          = 1'b1;
        map_wr_addr                        = slot_r[SLOT_W-1:BIT_W];
        map_wr_data.live[slot_r[BIT_W-1:0]] = 1'b1;
        if (cmd_r.is_vector) begin
          map_wr_data.vec[slot_r[BIT_W-1:0]] = 1'b1;
        end
        live_nxt           = live_r + 1'b1;
        res_nxt.given_slot = slot_r;
        state_nxt          = S_FINISH;
      end

      S_MARK_WR: begin
        map_wr_en                                     = 1'b1;
        map_wr_addr                                   = cmd_r.slot_number[SLOT_W-1:BIT_W];
        map_wr_data.mark[cmd_r.slot_number[BIT_W-1:0]] = 1'b1;
        res_nxt.already_marked = map_q.mark[cmd_r.slot_number[BIT_W-1:0]];
        state_nxt              = S_FINISH;
      end

      S_SW_RD: begin
        map_rd_en = 1'b1;
        state_nxt = S_SW_DAT;
      end

      // Write the swept word back at once; the freed bits are pushed after.
      S_SW_DAT: begin
        map_wr_en        = 1'b1;
        map_wr_data.live = map_q.live & map_q.mark;
        map_wr_data.mark = '0;
        map_wr_data.vec  = map_q.vec & ~sw_free;
        fmask_nxt        = sw_free;
        bit_nxt          = '0;
        state_nxt        = S_SW_BIT;
      end

      S_SW_BIT: begin
        if (fmask_r[bit_r]) begin
          freed_nxt = freed_r + 1'b1;
          if (free_depth_r < CNT_W'(TOTAL_SLOTS)) begin
            st_wr_en       = 1'b1;
            st_wr_data     = {word_r, bit_r};
            free_depth_nxt = free_depth_r + 1'b1;
          end
        end
        bit_nxt = bit_r + 1'b1;
        if (bit_r == BIT_W'(MAP_W - 1)) begin
          if ((CNT_W - BIT_W)'(word_r) + 1'b1 == limit_r[CNT_W-1:BIT_W]) begin
            state_nxt = S_SW_END;
          end else begin
            word_nxt  = word_r + 1'b1;
            state_nxt = S_SW_RD;
          end
        end
      end

      S_SW_END: begin
        live_nxt            = sw_live;
        thr_nxt             = (sw_twice > THR_W'(base_threshold_r)) ?
                              sw_twice : THR_W'(base_threshold_r);
        res_nxt.freed_count = freed_r;
        state_nxt           = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt          = res_r;
          out_data_nxt.live_count = live_r;
          state_nxt             = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      free_depth_r <= '0;
      chunks_r     <= '0;
      limit_r      <= '0;
      live_r       <= '0;
      thr_r        <= THR_W'(BASE_THR_RESET);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      free_depth_r <= free_depth_nxt;
      chunks_r     <= chunks_nxt;
      limit_r      <= limit_nxt;
      live_r       <= live_nxt;
      thr_r        <= thr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    push_cnt_r <= push_cnt_nxt;
    word_r     <= word_nxt;
    bit_r      <= bit_nxt;
    fmask_r    <= fmask_nxt;
    freed_r    <= freed_nxt;
    cmd_r      <= cmd_nxt;
    slot_r     <= slot_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------- assertions ----------------
  `MSA_ASSERT_NOW(a_depth_bound, 1'b1, free_depth_r <= CNT_W'(TOTAL_SLOTS),
    "free stack depth exceeds pool size")
  `MSA_ASSERT_NOW(a_live_bound, 1'b1, live_r <= limit_r,
    "live count exceeds active slots")
  `MSA_ASSERT_NEXT(a_act_done, (state_r == S_ACT) && (push_cnt_r == PUSH_W'(SLOTS_PER_CHUNK - 1)),
    free_depth_r != '0 && chunks_r <= CHUNK_W'(NUM_CHUNKS),
    "chunk activation left the free stack empty")

endmodule

// ===== hdl/msa_map_mem.sv =====
// ----------------------------------------------------------------------------
// msa_map_mem
// Bitmap memory: one word per 64 slots, registered read.
// ----------------------------------------------------------------------------
module msa_map_mem import msa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [WORD_W-1:0] rd_addr,
  output map_word_t         rd_data,
  input  logic              wr_en,
  input  logic [WORD_W-1:0] wr_addr,
  input  map_word_t         wr_data
);

  map_word_t              mem [MAP_WORDS];
  map_word_t              rd_q_r;
  logic                   rd_ok_r;
  logic [MAP_WORDS-1:0]   valid_r;

  // A word never written since reset reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= valid_r[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_ok_r ? rd_q_r : '0;

endmodule

// ===== dv/tb_mark_sweep_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// tb_mark_sweep_slot_allocator_unit
// Drives allocate, mark and sweep words into the slot allocator. A behavioral
// copy of the allocator state predicts every result word; typed directed rows
// supply their own status and slot. The run covers a directed table and random
// traffic under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_mark_sweep_slot_allocator_unit;
  import msa_pkg::*;

  localparam int LIMIT_CYCLES = 20000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_word_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mark_sweep_slot_allocator_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Allocator state as the predictor sees it.
  bit              slot_live [TOTAL_SLOTS];
  bit              slot_mark [TOTAL_SLOTS];
  bit              slot_vec  [TOTAL_SLOTS];
  int unsigned     free_lifo [$];
  int unsigned     chunks_on;
  int unsigned     live_now;
  int unsigned     thr_now;
  bit              en_now;
  int unsigned     base_now;

  out_word_t       pending_results [$];
  int unsigned     fail_cnt;
  int unsigned     sent_cnt;
  int unsigned     got_cnt;
  int unsigned     cycle_cnt;
  int unsigned     send_idle_pct;
  int unsigned     stall_pct;

  // Typed expectation riding along with a directed word.
  logic            row_typed;
  status_t         row_status;
  logic [SLOT_W-1:0] row_given;

  typedef struct {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic              vec;
    logic              typed;
    status_t           st;
    logic [SLOT_W-1:0] given;
  } row_t;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_word_t predict_allocator(in_word_t w);
    out_word_t   r;
    int unsigned freed;
    int unsigned twice;
    int unsigned s;
    r = '0;
    case (cmd_t'(w.command))
      CMD_ALLOC: begin
        if (en_now && live_now >= thr_now) begin
          r.status = STAT_COLLECT;
        end else begin
          if (free_lifo.size() == 0 && chunks_on < NUM_CHUNKS) begin
            for (int i = 0; i < SLOTS_PER_CHUNK; i++)
              free_lifo.push_back(chunks_on * SLOTS_PER_CHUNK + i);
            chunks_on++;
          end
          if (free_lifo.size() == 0) begin
            r.status = STAT_OOM;
          end else begin
            s = free_lifo.pop_back();
            slot_live[s] = 1'b1;
            if (w.is_vector) slot_vec[s] = 1'b1;
            live_now++;
            r.given_slot = s[SLOT_W-1:0];
          end
        end
      end
      CMD_MARK: begin
        if (w.slot_number >= chunks_on * SLOTS_PER_CHUNK) begin
          r.status = STAT_BADSLOT;
        end else begin
          r.already_marked = slot_mark[w.slot_number];
          slot_mark[w.slot_number] = 1'b1;
        end
      end
      CMD_SWEEP: begin
        freed = 0;
        for (int i = 0; i < chunks_on * SLOTS_PER_CHUNK; i++) begin
          if (slot_live[i] && !slot_mark[i]) begin
            slot_vec[i] = 1'b0;
            slot_live[i] = 1'b0;
            free_lifo.push_back(i);
            freed++;
          end
        end
        foreach (slot_mark[i]) slot_mark[i] = 1'b0;
        live_now = (freed <= live_now) ? live_now - freed : 0;
        twice = 2 * live_now;
        thr_now = ((twice > base_now) ? twice : base_now) & 14'h3fff;
        r.freed_count = freed[CNT_W-1:0];
      end
      default: ;
    endcase
    r.live_count = live_now[CNT_W-1:0];
    return r;
  endfunction

  // Accepted input words are predicted at the edge that takes them.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && in_valid && !in_stall) begin
      e = predict_allocator(in_data);
      if (row_typed) begin
        e.status = row_status;
        e.given_slot = row_given;
      end
      pending_results.push_back(e);
      sent_cnt++;
    end
  end

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && !out_stall) begin
      got_cnt++;
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected");
        fail_cnt++;
      end else begin
        e = pending_results.pop_front();
        if (out_data.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data.status);
          fail_cnt++;
        end
        if (out_data.given_slot !== e.given_slot) begin
          $error("given_slot: expected %0d, got %0d", e.given_slot, out_data.given_slot);
          fail_cnt++;
        end
        if (out_data.already_marked !== e.already_marked) begin
          $error("already_marked: expected %0d, got %0d", e.already_marked,
                 out_data.already_marked);
          fail_cnt++;
        end
        if (out_data.freed_count !== e.freed_count) begin
          $error("freed_count: expected %0d, got %0d", e.freed_count, out_data.freed_count);
          fail_cnt++;
        end
        if (out_data.live_count !== e.live_count) begin
          $error("live_count: expected %0d, got %0d", e.live_count, out_data.live_count);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(in_word_t w, logic typed, status_t st, logic [SLOT_W-1:0] given);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_data    <= w;
    row_typed  <= typed;
    row_status <= st;
    row_given  <= given;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_plain(cmd_t c, logic [SLOT_W-1:0] s, logic v);
    in_word_t w;
    w.command = c;
    w.slot_number = s;
    w.is_vector = v;
    send_word(w, 1'b0, STAT_OK, '0);
  endtask

  // Stop sending and hold off until every expected word is back.
  task automatic drain;
    in_valid  <= 1'b0;
    row_typed <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 3'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_COLLECT_ENABLE) en_now = value[0];
    else base_now = value[BASE_W-1:0];
    @(posedge clk);
  endtask

  task automatic random_phase(int unsigned n, int unsigned idle, int unsigned stall);
    int unsigned r;
    int unsigned span;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      span = chunks_on * SLOTS_PER_CHUNK;
      if (r < 55) begin
        send_plain(CMD_ALLOC, 12'($urandom), 1'($urandom));
      end else if (r < 90) begin
        // Mostly marks inside the active chunks, so sweeps keep some slots.
        if (span != 0 && $urandom_range(9) < 7)
          send_plain(CMD_MARK, 12'($urandom_range(span - 1)), 1'($urandom));
        else
          send_plain(CMD_MARK, 12'($urandom), 1'($urandom));
      end else if (r < 93) begin
        send_plain(CMD_SWEEP, 12'($urandom), 1'($urandom));
      end else if (r < 95) begin
        send_plain(CMD_NONE, 12'($urandom), 1'($urandom));
      end else begin
        send_plain(CMD_ALLOC, 12'($urandom), 1'($urandom));
      end
    end
    drain();
  endtask

  row_t dir_rows [16] = '{
    '{CMD_MARK,  12'd0,    1'b0, 1'b1, STAT_BADSLOT, 12'd0},
    '{CMD_SWEEP, 12'd0,    1'b0, 1'b1, STAT_OK,      12'd0},
    '{CMD_NONE,  12'hfff,  1'b1, 1'b1, STAT_OK,      12'd0},
    '{CMD_ALLOC, 12'd0,    1'b1, 1'b1, STAT_OK,      12'd255},
    '{CMD_ALLOC, 12'hfff,  1'b0, 1'b1, STAT_OK,      12'd254},
    '{CMD_MARK,  12'd255,  1'b0, 1'b1, STAT_OK,      12'd0},
    '{CMD_MARK,  12'd255,  1'b0, 1'b0, STAT_OK,      12'd0},
    '{CMD_MARK,  12'd100,  1'b0, 1'b0, STAT_OK,      12'd0},
    '{CMD_MARK,  12'd256,  1'b0, 1'b1, STAT_BADSLOT, 12'd0},
    '{CMD_MARK,  12'hfff,  1'b1, 1'b1, STAT_BADSLOT, 12'd0},
    '{CMD_SWEEP, 12'd0,    1'b0, 1'b0, STAT_OK,      12'd0},
    '{CMD_ALLOC, 12'd0,    1'b0, 1'b1, STAT_OK,      12'd254},
    '{CMD_ALLOC, 12'd0,    1'b1, 1'b1, STAT_OK,      12'd253},
    '{CMD_MARK,  12'd254,  1'b0, 1'b0, STAT_OK,      12'd0},
    '{CMD_NONE,  12'd0,    1'b0, 1'b1, STAT_OK,      12'd0},
    '{CMD_SWEEP, 12'd0,    1'b0, 1'b0, STAT_OK,      12'd0}
  };

  initial begin
    in_word_t w;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    row_typed = 1'b0;
    row_status = STAT_OK;
    row_given = '0;
    fail_cnt = 0;
    sent_cnt = 0;
    got_cnt = 0;
    cycle_cnt = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    chunks_on = 0;
    live_now = 0;
    en_now = 1'b0;
    base_now = BASE_THR_RESET;
    thr_now = BASE_THR_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      w.command = dir_rows[i].cmd;
      w.slot_number = dir_rows[i].slot;
      w.is_vector = dir_rows[i].vec;
      send_word(w, dir_rows[i].typed, dir_rows[i].st, dir_rows[i].given);
    end
    drain();

    // The threshold only moves at a sweep, so the refusal shows after one.
    write_reg(REG_COLLECT_ENABLE, 32'd1);
    write_reg(REG_BASE_THRESHOLD, 32'd1);
    for (int i = 0; i < 4; i++) send_plain(CMD_ALLOC, '0, 1'b0);
    send_plain(CMD_SWEEP, '0, 1'b0);
    for (int i = 0; i < 6; i++) send_plain(CMD_ALLOC, '0, 1'b1);
    drain();

    write_reg(REG_COLLECT_ENABLE, 32'd0);
    write_reg(REG_BASE_THRESHOLD, 32'd1024);
    random_phase(275, 0, 0);
    write_reg(REG_COLLECT_ENABLE, 32'd1);
    write_reg(REG_BASE_THRESHOLD, 32'd1);
    random_phase(275, 61, 0);
    write_reg(REG_BASE_THRESHOLD, 32'd4096);
    random_phase(275, 0, 61);
    write_reg(REG_BASE_THRESHOLD, 32'd40);
    random_phase(275, 17, 17);
    repeat (300) @(posedge clk);

    $display("Covered %0d words (%0d results) through directed rows and four random phases",
             sent_cnt, got_cnt);
    $display("with varied thresholds, collection on and off, and sender and receiver pauses.");
    if (fail_cnt == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== mark_sweep_slot_allocator_unit.f =====
+incdir+hdl
hdl/msa_pkg.sv
hdl/msa_map_mem.sv
hdl/mark_sweep_slot_allocator_unit.sv
dv/tb_mark_sweep_slot_allocator_unit.sv
